@@ hdl/caof_pkg.sv @@
package caof_pkg;

    localparam int ARENA_BYTES   = 4096;
    localparam int ARENA_AW      = $clog2(ARENA_BYTES);
    localparam int INDEX_MODULUS = 512;

    localparam logic [2:0] REQ_BYTE        = 3'd0;
    localparam logic [2:0] REQ_OPERAND     = 3'd1;
    localparam logic [2:0] REQ_OPERAND_MOD = 3'd2;
    localparam logic [2:0] REQ_STORE       = 3'd3;
    localparam logic [2:0] REQ_REG_WRITE   = 3'd4;

    localparam logic [1:0] ARG_REG      = 2'd0;
    localparam logic [1:0] ARG_DIRECT   = 2'd1;
    localparam logic [1:0] ARG_INDIRECT = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [11:0]        address;
        logic [4:0]         offset;
        logic [1:0]         arg_type;
        logic [2:0]         byte_count;
        logic [4:0]         reg_number;
        logic signed [31:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         next_offset;
        logic               bad_register;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_PTR,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       rd_en;
        logic       rd_ptr;
        logic [1:0] idx;
        logic       acc_clear;
        logic       acc_shift;
        logic       ptr_load;
        logic       wr_en;
        logic       rf_wr;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] arg_type;
        logic [2:0] cnt;
        logic       clear_last;
    } status_t;

    // Truncated remainder of a signed 16-bit offset by a power-of-two modulus.
    function automatic logic [15:0] index_rem(input logic [15:0] x);
        logic [15:0] mag;
        logic [15:0] r;
        mag = x[15] ? (16'd0 - x) : x;
        r   = mag & 16'(INDEX_MODULUS - 1);
        return x[15] ? (16'd0 - r) : r;
    endfunction

endpackage

@@ hdl/circular_arena_operand_fetch_core.sv @@
// Per item: accept, decode, then reads on the arena's single byte-wide read port: one
// byte for a byte or register operand, n for a direct operand (n = byte_count capped at
// 4, no reads when n is 0), a 2-byte offset then 4 bytes at the pointer for an indirect
// one; a store writes n bytes, a register write or unused request or kind neither. One
// item at a time: the next is taken in the cycle after the result is loaded.
// Reset: ctrl regs and register file clear at once; the arena sweeps to zero, in_ready low.
module circular_arena_operand_fetch_core
    import caof_pkg::*;
#(
    parameter int REG_COUNT = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    cmd_t    cmd;
    status_t status;

    caof_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    caof_dpath #(
        .REG_COUNT (REG_COUNT)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while previous item in flight");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && (cmd.wr_en || cmd.clear)))
        else $error("arena read and write in the same cycle");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

@@ hdl/caof_ctrl.sv @@
module caof_ctrl
    import caof_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic       pend_reg, pend_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] rd_len;
    logic       issue;
    logic       is_indirect;

    assign is_indirect = ((status.req_type == REQ_OPERAND) ||
                          (status.req_type == REQ_OPERAND_MOD)) &&
                         (status.arg_type == ARG_INDIRECT);

    always_comb
    begin
        if (status.req_type == REQ_BYTE)
            rd_len = 3'd1;
        else
        begin
            case (status.arg_type)
                ARG_REG:      rd_len = 3'd1;
                ARG_DIRECT:   rd_len = status.cnt;
                ARG_INDIRECT: rd_len = phase_reg ? 3'd4 : 3'd2;
                default:      rd_len = 3'd1;
            endcase
        end
    end

    assign issue = (k_reg != rd_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.acc_clear = 1'b1;
                k_next        = '0;
                pend_next     = 1'b0;
                phase_next    = 1'b0;
                case (status.req_type)
                    REQ_BYTE:
                        state_next = ST_READ;
                    REQ_OPERAND, REQ_OPERAND_MOD:
                    begin
                        case (status.arg_type)
                            ARG_REG:      state_next = ST_READ;
                            ARG_DIRECT:   state_next = (status.cnt == 3'd0) ? ST_DONE : ST_READ;
                            ARG_INDIRECT: state_next = ST_READ;
                            default:      state_next = ST_DONE;
                        endcase
                    end
                    REQ_STORE:
                        state_next = (status.cnt == 3'd0) ? ST_DONE : ST_STORE;
                    REQ_REG_WRITE:
                    begin
                        cmd.rf_wr  = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                // issue one byte a cycle, capture it the cycle after
                cmd.rd_en     = issue;
                cmd.rd_ptr    = phase_reg;
                cmd.idx       = k_reg[1:0];
                cmd.acc_shift = pend_reg;
                pend_next     = issue;
                if (issue)
                    k_next = k_reg + 3'd1;
                else if (is_indirect && !phase_reg)
                    state_next = ST_PTR;
                else
                    state_next = ST_DONE;
            end
            ST_PTR:
            begin
                cmd.ptr_load  = 1'b1;
                cmd.acc_clear = 1'b1;
                k_next        = '0;
                pend_next     = 1'b0;
                phase_next    = 1'b1;
                state_next    = ST_READ;
            end
            ST_STORE:
            begin
                cmd.wr_en = 1'b1;
                cmd.idx   = k_reg[1:0];
                k_next    = k_reg + 3'd1;
                if (k_reg == (status.cnt - 3'd1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/caof_dpath.sv @@
module caof_dpath
    import caof_pkg::*;
#(
    parameter int REG_COUNT = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t out_data
);

    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [7:0]          arena_mem [ARENA_BYTES];
    logic [31:0]         rf_reg [REG_COUNT];

    logic [2:0]          req_reg;
    logic [ARENA_AW-1:0] addr_reg;
    logic [4:0]          offs_reg;
    logic [1:0]          kind_reg;
    logic [2:0]          cnt_reg;
    logic [4:0]          regn_reg;
    logic [31:0]         data_reg;
    logic [ARENA_AW-1:0] pos_reg;
    logic [ARENA_AW-1:0] ptr_reg;
    logic [31:0]         acc_reg;
    logic [7:0]          rdata_reg;
    logic [ARENA_AW-1:0] clr_addr_reg;
    out_item_t           out_reg;

    logic [ARENA_AW-1:0] rd_addr;
    logic [ARENA_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                mem_we;
    logic [15:0]         ind;
    logic [ARENA_AW-1:0] ptr_next;
    logic                regn_ok;
    logic                rnum_ok;
    logic [RIW-1:0]      rf_wr_idx;
    logic [RIW-1:0]      rf_rd_idx;
    logic [31:0]         direct_val;
    out_item_t           res;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= in_data.req_type;
            addr_reg <= in_data.address;
            offs_reg <= in_data.offset;
            kind_reg <= in_data.arg_type;
            cnt_reg  <= (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
            regn_reg <= in_data.reg_number;
            pos_reg  <= in_data.address + ARENA_AW'(in_data.offset);
        end

        if (cmd.load)
            data_reg <= in_data.data_value;
        else if (cmd.wr_en)
            data_reg <= data_reg >> 8;

        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.acc_shift)
            acc_reg <= {acc_reg[23:0], rdata_reg};

        if (cmd.ptr_load)
            ptr_reg <= ptr_next;

        if (cmd.out_load)
            out_reg <= res;
    end

    // Indirect pointer: signed 16-bit offset, optionally reduced, from the instruction
    always_comb
    begin
        ind = acc_reg[15:0];
        if (req_reg == REQ_OPERAND_MOD)
            ind = index_rem(acc_reg[15:0]);
        ptr_next = addr_reg + ind[ARENA_AW-1:0];
    end

    // Arena: one write port, one registered read port
    assign rd_addr = (cmd.rd_ptr ? ptr_reg : pos_reg) + ARENA_AW'(cmd.idx);
    assign mem_we  = cmd.clear || cmd.wr_en;
    assign wr_addr = cmd.clear ? clr_addr_reg
                               : addr_reg + ARENA_AW'(cnt_reg - 3'd1 - {1'b0, cmd.idx});
    assign wr_data = cmd.clear ? 8'd0 : data_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            arena_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= arena_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + ARENA_AW'(1);
    end

    // Register file
    assign regn_ok   = (regn_reg != 5'd0) && (32'(regn_reg) <= REG_COUNT);
    assign rnum_ok   = (acc_reg[7:0] != 8'd0) && (32'(acc_reg[7:0]) <= REG_COUNT);
    assign rf_wr_idx = RIW'(regn_reg - 5'd1);
    assign rf_rd_idx = RIW'(acc_reg[7:0] - 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= '0;
        end
        else if (cmd.rf_wr && regn_ok)
            rf_reg[rf_wr_idx] <= data_reg;
    end

    // Sign-extend a big-endian direct operand by its size
    always_comb
    begin
        case (cnt_reg)
            3'd1:    direct_val = {{24{acc_reg[7]}}, acc_reg[7:0]};
            3'd2:    direct_val = {{16{acc_reg[15]}}, acc_reg[15:0]};
            3'd3:    direct_val = {{8{acc_reg[23]}}, acc_reg[23:0]};
            3'd4:    direct_val = acc_reg;
            default: direct_val = '0;
        endcase
    end

    always_comb
    begin
        res = '0;
        case (req_reg)
            REQ_BYTE:
            begin
                res.value       = {24'd0, acc_reg[7:0]};
                res.next_offset = {1'b0, offs_reg} + 6'd1;
            end
            REQ_OPERAND, REQ_OPERAND_MOD:
            begin
                case (kind_reg)
                    ARG_REG:
                    begin
                        if (rnum_ok)
                            res.value = rf_reg[rf_rd_idx];
                        else
                            res.bad_register = 1'b1;
                        res.next_offset = {1'b0, offs_reg} + 6'd1;
                    end
                    ARG_DIRECT:
                    begin
                        res.value       = direct_val;
                        res.next_offset = {1'b0, offs_reg} + 6'(cnt_reg);
                    end
                    ARG_INDIRECT:
                    begin
                        res.value       = acc_reg;
                        res.next_offset = {1'b0, offs_reg} + 6'd2;
                    end
                    default:
                        res.next_offset = {1'b0, offs_reg};
                endcase
            end
            REQ_REG_WRITE:
                res.bad_register = !regn_ok;
            default:
                res = '0;
        endcase
    end

    assign status.req_type   = req_reg;
    assign status.arg_type   = kind_reg;
    assign status.cnt        = cnt_reg;
    assign status.clear_last = (clr_addr_reg == {ARENA_AW{1'b1}});

    assign out_data = out_reg;

endmodule
